>>> sv/nisd_pkg.sv
// ----------------------------------------------------------------------------
// nisd_pkg
// Types, constants and helpers shared by the NEC IR symbol decoder modules.
// ----------------------------------------------------------------------------
package nisd_pkg;

    localparam int MAX_SYMBOLS = 64;
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);

    localparam int DUR_W    = 15;
    localparam int MARGIN_W = 9;
    localparam int CMP_W    = 16;

    localparam logic [CMP_W-1:0] LEAD_MARK  = 16'd9000;
    localparam logic [CMP_W-1:0] LEAD_SPACE = 16'd4500;
    localparam logic [CMP_W-1:0] BIT_MARK   = 16'd560;
    localparam logic [CMP_W-1:0] ZERO_SPACE = 16'd560;
    localparam logic [CMP_W-1:0] ONE_SPACE  = 16'd1690;
    localparam logic [CMP_W-1:0] RPT_MARK   = 16'd9000;
    localparam logic [CMP_W-1:0] RPT_SPACE  = 16'd2250;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 9'd200;

    localparam int FRAME_LEN  = 34;
    localparam int REPEAT_LEN = 2;
    localparam int ADDR_BITS  = 16;
    localparam int CMD_BITS   = 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [DUR_W-1:0] mark_duration;
        logic [DUR_W-1:0] space_duration;
        logic             last_symbol;
    } t_sym_in;

    typedef struct packed {
        logic [ADDR_BITS-1:0] address;
        logic [CMD_BITS-1:0]  command;
        logic                 rpt_flag;
    } t_sym_out;

    // Classified symbol passed from the front end to the burst engine
    typedef struct packed {
        logic is_lead;
        logic is_rpt;
        logic is_one;
        logic is_zero;
        logic last;
    } t_sym_class;

    // Strictly inside nominal +/- margin
    function automatic logic dur_near(input logic [DUR_W-1:0]    d,
                                      input logic [CMP_W-1:0]    nom,
                                      input logic [MARGIN_W-1:0] m);
        logic [CMP_W-1:0] dd;
        logic [CMP_W-1:0] mm;
        dd = CMP_W'(d);
        mm = CMP_W'(m);
        return (dd < nom + mm) && (dd + mm > nom);
    endfunction

endpackage

>>> sv/nisd_front.sv
// ----------------------------------------------------------------------------
// nisd_front
// Holds the tolerance register and classifies each incoming symbol against
// the nominal NEC timings.
// ----------------------------------------------------------------------------
module nisd_front import nisd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [MARGIN_W-1:0] i_cfg_data,
    input  t_sym_in             i_sym,
    output t_sym_class          o_class
);

    logic [MARGIN_W-1:0] r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
        end else if (i_cfg_valid) begin
            r_margin <= i_cfg_data;
        end
    end

    logic mark_lead;
    logic mark_bit;

    assign mark_lead = dur_near(i_sym.mark_duration, LEAD_MARK, r_margin);
    assign mark_bit  = dur_near(i_sym.mark_duration, BIT_MARK, r_margin);

    always_comb begin
        o_class.is_lead = mark_lead && dur_near(i_sym.space_duration, LEAD_SPACE, r_margin);
        o_class.is_rpt  = dur_near(i_sym.mark_duration, RPT_MARK, r_margin)
                          && dur_near(i_sym.space_duration, RPT_SPACE, r_margin);
        o_class.is_one  = mark_bit && dur_near(i_sym.space_duration, ONE_SPACE, r_margin);
        o_class.is_zero = mark_bit && dur_near(i_sym.space_duration, ZERO_SPACE, r_margin);
        o_class.last    = i_sym.last_symbol;
    end

endmodule

>>> sv/nisd_fifo.sv
// ----------------------------------------------------------------------------
// nisd_fifo
// Short queue of classified symbols between the front end and burst engine.
// ----------------------------------------------------------------------------
module nisd_fifo import nisd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_sym_class i_data,
    input  logic       i_pop,
    output t_sym_class o_data,
    output logic       o_full,
    output logic       o_empty
);

    t_sym_class               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       r_wr_ptr;
    logic [FIFO_AW-1:0]       r_rd_ptr;
    logic [FIFO_CW-1:0]       r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("fifo count above depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != FIFO_CW'(FIFO_DEPTH))
            |-> (r_wr_ptr - r_rd_ptr) == FIFO_AW'(r_count))
        else $error("fifo pointers disagree with count");

endmodule

>>> sv/nisd_back.sv
// ----------------------------------------------------------------------------
// nisd_back
// Burst engine: counts symbols, assembles address and command, and issues a
// result beat at burst end through a single output register.
// ----------------------------------------------------------------------------
module nisd_back import nisd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_sym_class i_class,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_sym_out   o_out_data
);

    logic [CNT_W-1:0]     r_count;
    logic [ADDR_BITS-1:0] r_addr;
    logic [CMD_BITS-1:0]  r_cmd;
    logic                 r_good;
    logic                 r_rpt;
    logic [ADDR_BITS-1:0] r_saved_addr;
    logic [CMD_BITS-1:0]  r_saved_cmd;
    logic                 r_out_valid;
    t_sym_out             r_out;

    logic [CNT_W-1:0]     n_count;
    logic [ADDR_BITS-1:0] n_addr;
    logic [CMD_BITS-1:0]  n_cmd;
    logic                 n_good;
    logic                 n_rpt;
    logic                 bit_ok;
    logic [3:0]           addr_pos;
    logic [3:0]           cmd_pos;
    logic                 frame_hit;
    logic                 rpt_hit;

    assign o_pop       = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign bit_ok   = i_class.is_one || i_class.is_zero;
    assign addr_pos = 4'(r_count - CNT_W'(1));
    assign cmd_pos  = 4'(r_count - CNT_W'(17));

    always_comb begin
        n_addr = r_addr;
        n_cmd  = r_cmd;
        n_good = r_good;
        n_rpt  = r_rpt;
        if (r_count == '0) begin
            n_good = i_class.is_lead;
            n_rpt  = i_class.is_rpt;
        end else if (r_count <= CNT_W'(16)) begin
            if (bit_ok) n_addr[addr_pos] = i_class.is_one;
            else        n_good = 1'b0;
        end else if (r_count <= CNT_W'(32)) begin
            // only the low command byte is ever reported
            if (!bit_ok)                  n_good = 1'b0;
            else if (cmd_pos < 4'(CMD_BITS)) n_cmd[cmd_pos[2:0]] = i_class.is_one;
        end
        n_count = (r_count < CNT_W'(MAX_SYMBOLS)) ? r_count + 1'b1 : r_count;
    end

    assign frame_hit = i_class.last && (n_count == CNT_W'(FRAME_LEN)) && n_good;
    assign rpt_hit   = i_class.last && (n_count == CNT_W'(REPEAT_LEN)) && n_rpt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_addr       <= '0;
            r_cmd        <= '0;
            r_good       <= 1'b1;
            r_rpt        <= 1'b0;
            r_saved_addr <= '0;
            r_saved_cmd  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop && (frame_hit || rpt_hit)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_class.last) begin
                    r_count <= '0;
                    r_addr  <= '0;
                    r_cmd   <= '0;
                    r_good  <= 1'b1;
                    r_rpt   <= 1'b0;
                end else begin
                    r_count <= n_count;
                    r_addr  <= n_addr;
                    r_cmd   <= n_cmd;
                    r_good  <= n_good;
                    r_rpt   <= n_rpt;
                end
                if (frame_hit) begin
                    r_saved_addr <= n_addr;
                    r_saved_cmd  <= n_cmd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && frame_hit) begin
            r_out.address  <= n_addr;
            r_out.command  <= n_cmd;
            r_out.rpt_flag <= 1'b0;
        end else if (o_pop && rpt_hit) begin
            r_out.address  <= r_saved_addr;
            r_out.command  <= r_saved_cmd;
            r_out.rpt_flag <= 1'b1;
        end
    end

    a_burst_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_class.last) |=> (r_count == '0 && r_good && !r_rpt))
        else $error("burst state not cleared after last symbol");

    a_result_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_pop && i_class.last))
        else $error("result issued without burst end");

    a_no_pop_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_pop)
        else $error("symbol consumed while result held");

endmodule

>>> sv/nec_ir_symbol_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_symbol_decoder
// NEC infrared frame decoder working on one mark/space symbol per beat.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one symbol per
// beat: mark and space durations in microseconds plus the last-symbol flag.
// A 34-symbol burst with a good leader and 32 valid data bits yields one
// result beat (address, command low byte, rpt_flag = 0). A 2-symbol burst
// starting with the repeat header yields the last good address and command
// with rpt_flag = 1. Other bursts give nothing. Results leave on the output
// channel (o_out_valid / i_out_stall / o_out_data) only at burst end.
// One symbol is accepted per cycle while o_in_stall is low. o_out_valid is
// registered: the last symbol passes through the queue register, then the
// output register, which loads only when it is empty or not stalled.
// A 4-entry symbol queue sits between the classifier
// and the burst engine; when the receiver stalls with a result pending, the
// engine holds and the queue absorbs up to 4 more symbols before o_in_stall
// rises. The tolerance register is written on the cfg channel (always ready)
// and resets to 200 us. Reset clears the burst state and saved address and
// command to zero.
// ----------------------------------------------------------------------------
module nec_ir_symbol_decoder import nisd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [MARGIN_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_sym_in             i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_sym_out            o_out_data
);

    t_sym_class sym_class;
    t_sym_class head_class;
    logic       fifo_full;
    logic       fifo_empty;
    logic       pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = fifo_full;

    nisd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_sym       (i_in_data),
        .o_class     (sym_class)
    );

    nisd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (sym_class),
        .i_pop   (pop),
        .o_data  (head_class),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    nisd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (fifo_empty),
        .i_class     (head_class),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> verif/nec_ir_frame_checker.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_checker
// Watches the decoder's channels, predicts each result beat and compares it.
// ----------------------------------------------------------------------------
// Keeps its own copy of the tolerance register (tracked from the cfg channel)
// and of the burst state. Every accepted symbol runs through the decoder
// prediction. A predicted result is queued. Every accepted result beat is
// checked field by field against the oldest queued one. The failure count
// and the number of results still due go back to the testbench top.
// ----------------------------------------------------------------------------
module nec_ir_frame_checker import nisd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [MARGIN_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  t_sym_in             i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  t_sym_out            i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [MARGIN_W-1:0] margin = MARGIN_RESET;
    logic [CNT_W-1:0]    sym_cnt = '0;
    logic [15:0]         addr_acc = '0;
    logic [15:0]         cmd_acc = '0;
    logic                frame_ok = 1'b1;
    logic                rpt_hit = 1'b0;
    logic [15:0]         last_addr = '0;
    logic [15:0]         last_cmd = '0;

    t_sym_out frame_due_q[$];
    int       fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    // strictly inside nominal +/- margin
    function automatic logic dur_ok(int d, int nom);
        return (d < nom + int'(margin)) && (d + int'(margin) > nom);
    endfunction

    function automatic logic sym_is(t_sym_in s, logic [CMP_W-1:0] nom_mark,
                                    logic [CMP_W-1:0] nom_space);
        return dur_ok(int'(s.mark_duration), int'(nom_mark)) &&
               dur_ok(int'(s.space_duration), int'(nom_space));
    endfunction

    task automatic clear_burst();
        sym_cnt  = '0;
        addr_acc = '0;
        cmd_acc  = '0;
        frame_ok = 1'b1;
        rpt_hit  = 1'b0;
    endtask

    task automatic take_bit(inout logic [15:0] acc, input logic [3:0] pos, input t_sym_in s);
        if (sym_is(s, BIT_MARK, ONE_SPACE)) begin
            acc[pos] = 1'b1;
        end else if (sym_is(s, BIT_MARK, ZERO_SPACE)) begin
            acc[pos] = 1'b0;
        end else begin
            frame_ok = 1'b0;
        end
    endtask

    task automatic decode_symbol(t_sym_in s);
        int       c;
        t_sym_out r;
        c = int'(sym_cnt);
        if (c == 0) begin
            frame_ok = sym_is(s, LEAD_MARK, LEAD_SPACE);
            rpt_hit  = sym_is(s, RPT_MARK, RPT_SPACE);
        end else if (c <= 16) begin
            take_bit(addr_acc, 4'(c - 1), s);
        end else if (c <= 32) begin
            take_bit(cmd_acc, 4'(c - 17), s);
        end
        // stop symbol and anything after it only count
        if (c < MAX_SYMBOLS) c++;
        sym_cnt = CNT_W'(c);
        if (s.last_symbol) begin
            if (c == FRAME_LEN && frame_ok) begin
                last_addr  = addr_acc;
                last_cmd   = cmd_acc;
                r.address  = last_addr;
                r.command  = last_cmd[CMD_BITS-1:0];
                r.rpt_flag = 1'b0;
                frame_due_q.push_back(r);
            end else if (c == REPEAT_LEN && rpt_hit) begin
                r.address  = last_addr;
                r.command  = last_cmd[CMD_BITS-1:0];
                r.rpt_flag = 1'b1;
                frame_due_q.push_back(r);
            end
            clear_burst();
        end
    endtask

    task automatic note_fail();
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_sym_out got;
        t_sym_out want;
        if (!i_rst_n) begin
            margin    = MARGIN_RESET;
            last_addr = '0;
            last_cmd  = '0;
            clear_burst();
            frame_due_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) margin = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (frame_due_q.size() == 0) begin
                    $error("unexpected result beat: address %h command %h rpt_flag %b",
                           got.address, got.command, got.rpt_flag);
                    note_fail();
                end else begin
                    want = frame_due_q.pop_front();
                    if (got.address !== want.address) begin
                        $error("address: expected %h, got %h", want.address, got.address);
                        note_fail();
                    end
                    if (got.command !== want.command) begin
                        $error("command: expected %h, got %h", want.command, got.command);
                        note_fail();
                    end
                    if (got.rpt_flag !== want.rpt_flag) begin
                        $error("rpt_flag: expected %b, got %b",
                               want.rpt_flag, got.rpt_flag);
                        note_fail();
                    end
                end
            end
            if (i_in_valid && !i_in_stall) decode_symbol(i_in_data);
        end
        o_pending = frame_due_q.size();
    end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the NEC IR symbol decoder.
// ----------------------------------------------------------------------------
// Drives symbol bursts (good frames, repeats, spoiled frames, odd lengths,
// saturating bursts and noise) under several tolerance settings, with bursty
// input gaps and a receiver that stalls on its own pattern, including one
// long hold-off that backs the decoder up. Checking sits in
// nec_ir_frame_checker; this module only drives and reports the outcome.
// ----------------------------------------------------------------------------
module tb;
    import nisd_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT       = 5_000_000;

    typedef enum int {RX_FLOW, RX_CHOPPY, RX_BLOCK} t_rx_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [MARGIN_W-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_sym_in             in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_sym_out            out_data;

    int fail_count;
    int pending;

    int cur_margin = int'(MARGIN_RESET);
    int sent = 0;
    int run_left = 0;
    logic gaps_on = 1'b1;
    int hold_ask = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    nec_ir_symbol_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    nec_ir_frame_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // ---- symbol construction ----

    function automatic t_sym_in raw_sym(int m, int sp, logic last);
        t_sym_in s;
        s.mark_duration  = DUR_W'(m);
        s.space_duration = DUR_W'(sp);
        s.last_symbol    = last;
        return s;
    endfunction

    // duration that matches nom under the current margin (when one exists)
    function automatic int near_dur(int nom);
        int m;
        int off;
        m = cur_margin;
        if (m <= 1) return nom;
        case ($urandom_range(0, 9))
            0: off = -(m - 1);
            1: off = m - 1;
            default: off = int'($urandom_range(0, 2 * (m - 1))) - (m - 1);
        endcase
        return nom + off;
    endfunction

    // just outside the match window
    function automatic int edge_dur(int nom);
        return $urandom_range(0, 1) ? nom + cur_margin : nom - cur_margin;
    endfunction

    function automatic t_sym_in good_sym(int nm, int ns, logic last);
        return raw_sym(near_dur(nm), near_dur(ns), last);
    endfunction

    function automatic t_sym_in rand_sym(logic last);
        return raw_sym($urandom_range(0, 32767), $urandom_range(0, 32767), last);
    endfunction

    function automatic t_sym_in bad_sym(logic last);
        int sp;
        sp = $urandom_range(0, 1) ? int'(ONE_SPACE) : int'(ZERO_SPACE);
        case ($urandom_range(0, 3))
            0: return rand_sym(last);
            1: return raw_sym(edge_dur(int'(BIT_MARK)), near_dur(sp), last);
            2: return raw_sym(near_dur(int'(BIT_MARK)), edge_dur(sp), last);
            default: return raw_sym(near_dur(int'(BIT_MARK)), $urandom_range(0, 3000), last);
        endcase
    endfunction

    // ---- channel drivers ----

    task automatic send_sym(t_sym_in s);
        int idle;
        idle = 0;
        if (gaps_on) begin
            if (run_left > 0) begin
                run_left--;
            end else begin
                run_left = $urandom_range(0, 40);
                idle = $urandom_range(1, 12);
            end
        end
        repeat (idle) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge i_clk); while (in_stall);
        sent++;
    endtask

    // frame-shaped burst: leader, address bits, command bits, then filler
    task automatic send_frame(int len, int bad_at, logic [15:0] addr, logic [15:0] cmd);
        logic    last;
        t_sym_in s;
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            if (i == bad_at)
                s = bad_sym(last);
            else if (i == 0)
                s = good_sym(int'(LEAD_MARK), int'(LEAD_SPACE), last);
            else if (i <= 16)
                s = good_sym(int'(BIT_MARK),
                             addr[i-1] ? int'(ONE_SPACE) : int'(ZERO_SPACE), last);
            else if (i <= 32)
                s = good_sym(int'(BIT_MARK),
                             cmd[i-17] ? int'(ONE_SPACE) : int'(ZERO_SPACE), last);
            else if (i == 33)
                s = good_sym(int'(BIT_MARK), int'(ZERO_SPACE), last);
            else
                s = rand_sym(last);
            send_sym(s);
        end
    endtask

    task automatic send_repeat(logic hdr_ok, int len);
        logic last;
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            if (i == 0)
                send_sym(hdr_ok ? good_sym(int'(RPT_MARK), int'(RPT_SPACE), last)
                                : bad_sym(last));
            else if ($urandom_range(0, 1))
                send_sym(good_sym(int'(BIT_MARK), int'(ZERO_SPACE), last));
            else
                send_sym(rand_sym(last));
        end
    endtask

    task automatic send_noise(int len);
        for (int i = 0; i < len; i++) send_sym(rand_sym(i == len - 1));
    endtask

    // drop valid, let every due result arrive, then let the symbol queue drain
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_margin(int m);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= MARGIN_W'(m);
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        cur_margin = m;
    endtask

    task automatic run_random(int n_items);
        int stop_at;
        int pick;
        logic [15:0] addr;
        logic [15:0] cmd;
        stop_at = sent + n_items;
        while (sent < stop_at) begin
            pick = $urandom_range(0, 99);
            addr = 16'($urandom);
            cmd  = 16'($urandom);
            if (pick < 45)
                send_frame(FRAME_LEN, -1, addr, cmd);
            else if (pick < 60)
                send_repeat(1'b1, REPEAT_LEN);
            else if (pick < 72)
                send_frame(FRAME_LEN, $urandom_range(0, 32), addr, cmd);
            else if (pick < 80)
                send_frame($urandom_range(1, 40), -1, addr, cmd);
            else if (pick < 83)
                send_frame($urandom_range(60, 130), -1, addr, cmd);   // count saturates
            else if (pick < 88)
                send_repeat(1'($urandom_range(0, 1)), $urandom_range(1, 4));
            else if (pick < 93)
                send_noise($urandom_range(1, 4));
            else
                send_repeat(1'b0, REPEAT_LEN);
        end
    endtask

    // ---- receiver ----

    initial begin
        int       seen;
        int       len;
        t_rx_mode mode;
        seen = 0;
        forever begin
            if (hold_ask != seen) begin
                seen = hold_ask;
                mode = RX_BLOCK;
                len  = HOLD_CYCLES;
            end else begin
                mode = t_rx_mode'($urandom_range(0, 2));
                len  = (mode == RX_BLOCK) ? $urandom_range(1, 8) : $urandom_range(1, 30);
            end
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    RX_FLOW:   out_stall <= 1'b0;
                    RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
                    default:   out_stall <= 1'b1;
                endcase
            end
        end
    end

    // ---- main sequence ----

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: repeat before any frame returns the reset address/command
        send_sym(good_sym(int'(RPT_MARK), int'(RPT_SPACE), 1'b0));
        send_sym(raw_sym(int'(BIT_MARK), int'(ZERO_SPACE), 1'b1));
        // field extremes, one- and two-symbol bursts
        send_sym(raw_sym(32767, 32767, 1'b1));
        send_sym(raw_sym(0, 0, 1'b1));
        send_sym(raw_sym(32767, 0, 1'b0));
        send_sym(raw_sym(0, 32767, 1'b1));
        // leader in a two-symbol burst is no repeat
        send_sym(raw_sym(int'(LEAD_MARK), int'(LEAD_SPACE), 1'b0));
        send_sym(raw_sym(int'(BIT_MARK), int'(ZERO_SPACE), 1'b1));
        // repeat header in a three-symbol burst
        send_sym(raw_sym(int'(RPT_MARK), int'(RPT_SPACE), 1'b0));
        send_sym(raw_sym(int'(BIT_MARK), int'(ZERO_SPACE), 1'b0));
        send_sym(raw_sym(int'(BIT_MARK), int'(ONE_SPACE), 1'b1));
        // header exactly on the window edge does not match
        send_sym(raw_sym(int'(RPT_MARK) + int'(MARGIN_RESET), int'(RPT_SPACE), 1'b0));
        send_sym(raw_sym(int'(BIT_MARK), int'(ZERO_SPACE), 1'b1));
        send_sym(raw_sym(int'(RPT_MARK), int'(RPT_SPACE) - int'(MARGIN_RESET), 1'b0));
        send_sym(raw_sym(int'(BIT_MARK), int'(ZERO_SPACE), 1'b1));

        // output extremes, each followed by a repeat
        send_frame(FRAME_LEN, -1, 16'hFFFF, 16'h00FF);
        send_repeat(1'b1, REPEAT_LEN);
        send_frame(FRAME_LEN, -1, 16'h0000, 16'hFF00);
        send_repeat(1'b1, REPEAT_LEN);
        run_random(300);
        settle();

        write_margin(0);        // nothing can match
        run_random(120);
        settle();

        write_margin(500);
        hold_ask++;             // long receiver hold-off while frames keep coming
        run_random(325);
        settle();

        write_margin(1);        // only exact nominals match
        gaps_on = 1'b0;
        run_random(275);
        gaps_on = 1'b1;
        settle();

        write_margin($urandom_range(2, 499));
        run_random(300);
        settle();

        write_margin(int'(MARGIN_RESET));
        run_random(300);
        settle();

        if (fail_count == 0) begin
            $display("nec_ir_symbol_decoder: match");
        end else begin
            $display("nec_ir_symbol_decoder: mismatch");
        end
        $finish;
    end

    initial begin
        #TIMEOUT;
        $display("nec_ir_symbol_decoder: mismatch");
        $finish;
    end

endmodule
